FILE: sv/rcwc_pkg.sv
// ----------------------------------------------------------------------------
// rcwc_pkg: shared types and constants
// Types, codes and fixed constants for the Reno window control block.
// ----------------------------------------------------------------------------
package rcwc_pkg;

  localparam int SeqBitsDefault  = 16;
  localparam int WinFracDefault  = 8;
  localparam int WinW            = 24;
  localparam int ThrW            = 16;
  localparam int LimW            = 19;
  localparam int RttW            = 24;
  localparam int CfgW            = 16;

  localparam logic [1:0] CMD_ACK     = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_SEND    = 2'd2;

  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_AVOID = 2'd1;
  localparam logic [1:0] PH_FAST  = 2'd2;

  localparam logic [1:0] REG_INIT_THR  = 2'd0;
  localparam logic [1:0] REG_FIRST_BASE = 2'd1;
  localparam logic [1:0] REG_FINAL_SEQ = 2'd2;

  localparam logic [RttW-1:0] MeanReset = RttW'(16000);

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] ack_number;
    logic        ack_good;
    logic [15:0] rtt_sample;
  } in_item_t;

  typedef struct packed {
    logic            send_granted;
    logic [15:0]     send_number;
    logic            rewound;
    logic [1:0]      phase;
    logic [WinW-1:0] window;
    logic [ThrW-1:0] threshold;
    logic [15:0]     acked_base;
    logic            transfer_done;
    logic [LimW-1:0] timer_limit;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic div_start;  // start reciprocal division
    logic div_step;   // one quotient bit
    logic commit;     // apply state update and build result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;   // item is an in-order ack in avoidance
    logic div_done;
  } dp_status_t;

endpackage

FILE: sv/rcwc_ctrl.sv
// ----------------------------------------------------------------------------
// rcwc_ctrl: sequencing controller
// Accepts an item, runs the divider when needed, commits and holds the result.
// ----------------------------------------------------------------------------
module rcwc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  rcwc_pkg::dp_status_t status_i,
  output rcwc_pkg::dp_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       accept;

  // input waits while busy or while a held result is being stalled
  assign in_stall_o  = (state_q != S_IDLE) || (ovalid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          ovalid_d     = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

FILE: sv/rcwc_dp.sv
// ----------------------------------------------------------------------------
// rcwc_dp: window, sequence and rtt datapath
// Holds the protocol state, the restoring divider and the result register.
// ----------------------------------------------------------------------------
module rcwc_dp #(
  parameter int WinFrac = rcwc_pkg::WinFracDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [rcwc_pkg::CfgW-1:0] cfg_data_i,
  input  rcwc_pkg::in_item_t        in_data_i,
  input  rcwc_pkg::dp_cmd_t         cmd_i,
  output rcwc_pkg::dp_status_t      status_o,
  output rcwc_pkg::out_item_t       out_data_o
);

  localparam int SeqBits = rcwc_pkg::SeqBitsDefault;
  localparam int WinW  = rcwc_pkg::WinW;
  localparam int ThrW  = rcwc_pkg::ThrW;
  localparam int RttW  = rcwc_pkg::RttW;
  localparam int LimW  = rcwc_pkg::LimW;
  localparam int NumW  = 2 * WinFrac + 1;          // dividend width
  localparam int QW    = NumW;                     // quotient width
  localparam int CntW  = $clog2(NumW + 1);
  localparam int ExtW  = WinW + ThrW + 4;
  localparam logic [WinW-1:0] WinOne = WinW'(1) << WinFrac;
  localparam logic [WinW-1:0] WinMax = '1;

  // state
  logic [1:0]         phase_q;
  logic [WinW-1:0]    win_q;
  logic [ThrW-1:0]    thr_q;
  logic [1:0]         dup_q;
  logic [SeqBits-1:0] base_q, next_q, final_q;
  logic [RttW-1:0]    mean_q, dev_q;
  logic               done_q;
  rcwc_pkg::in_item_t item_q;
  rcwc_pkg::out_item_t res_q;

  // divider
  logic [WinW-1:0]  rem_q;
  logic [QW-1:0]    quo_q;
  logic [NumW-1:0]  num_q;
  logic [CntW-1:0]  cnt_q;
  logic [WinW:0]    trial;

  logic [SeqBits-1:0] ack, ack_dist, outst;
  assign ack      = SeqBits'(item_q.ack_number);
  assign ack_dist = ack - base_q;
  assign outst    = next_q - base_q;

  logic is_ack;
  assign is_ack = (item_q.command == rcwc_pkg::CMD_ACK) && item_q.ack_good && !done_q;
  assign status_o.need_div = is_ack && (ack_dist == SeqBits'(1)) &&
                             (phase_q == rcwc_pkg::PH_AVOID) && (win_q != '0);
  assign status_o.div_done = (cnt_q == CntW'(1));

  assign trial = {rem_q, num_q[NumW-1]} - {1'b0, win_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= '0;
      num_q <= NumW'(1) << (2 * WinFrac);
    end else if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      if (!trial[WinW]) begin
        rem_q <= trial[WinW-1:0];
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[WinW-2:0], num_q[NumW-1]};
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= CntW'(NumW);
    end else if (cmd_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // saturating helpers
  function automatic logic [WinW-1:0] sat(input logic [ExtW-1:0] v);
    sat = (v > ExtW'(WinMax)) ? WinMax : v[WinW-1:0];
  endfunction

  logic [ExtW-1:0] thr_win, halfw;
  logic [ThrW-1:0] half_thr;
  assign halfw    = ExtW'(win_q >> (WinFrac + 1));
  assign half_thr = (halfw > ExtW'({ThrW{1'b1}})) ? '1 : halfw[ThrW-1:0];
  assign thr_win  = ExtW'(thr_q) << WinFrac;

  // rtt update
  logic [RttW+3:0] mean_sum, s8, diff, dev_sum;
  logic [RttW-1:0] mean_new, dev_new;
  assign s8       = (RttW+4)'(item_q.rtt_sample) << 3;
  assign mean_sum = ((RttW+4)'(mean_q) << 3) - (RttW+4)'(mean_q) + s8;
  assign mean_new = mean_sum[RttW+2:3];
  assign diff     = (s8 > (RttW+4)'(mean_new)) ? s8 - (RttW+4)'(mean_new)
                                               : (RttW+4)'(mean_new) - s8;
  assign dev_sum  = ((RttW+4)'(dev_q) << 1) + (RttW+4)'(dev_q) + diff;
  assign dev_new  = dev_sum[RttW+1:2];

  // next state
  logic [1:0]         phase_d;
  logic [WinW-1:0]    win_d;
  logic [ThrW-1:0]    thr_d;
  logic [1:0]         dup_d;
  logic [SeqBits-1:0] base_d, next_d;
  logic [RttW-1:0]    mean_d, dev_d;
  logic               done_d, grant, rew;
  logic [SeqBits-1:0] num;
  logic [ExtW-1:0]    lim_sum;
  logic [LimW-1:0]    lim;

  always_comb begin
    phase_d = phase_q; win_d = win_q; thr_d = thr_q; dup_d = dup_q;
    base_d = base_q; next_d = next_q; mean_d = mean_q; dev_d = dev_q;
    done_d = done_q; grant = 1'b0; rew = 1'b0; num = '0;
    if (is_ack) begin
      if (ack_dist == SeqBits'(1)) begin
        mean_d = mean_new; dev_d = dev_new; base_d = ack;
        if (outst == '0) next_d = ack;
        priority if (phase_q == rcwc_pkg::PH_SLOW) begin
          win_d = sat(ExtW'(win_q) + ExtW'(WinOne));
        end else if (phase_q == rcwc_pkg::PH_AVOID) begin
          if (win_q == '0) win_d = WinOne;
          else win_d = sat(ExtW'(win_q) + ExtW'(quo_q));
        end else begin
          win_d = sat(thr_win);
          phase_d = rcwc_pkg::PH_AVOID;
        end
        dup_d = '0;
        if (phase_d == rcwc_pkg::PH_SLOW && ExtW'(win_d) >= thr_win)
          phase_d = rcwc_pkg::PH_AVOID;
        if (ack == final_q) done_d = 1'b1;
      end else if (ack_dist > SeqBits'(1) && ack_dist <= outst) begin
        mean_d = mean_new; dev_d = dev_new; base_d = ack;
        if (ack == final_q) done_d = 1'b1;
      end else if (ack_dist == '0) begin
        if (phase_q == rcwc_pkg::PH_FAST) begin
          win_d = sat(ExtW'(win_q) + ExtW'(WinOne));
        end else begin
          if (dup_q != 2'd3) dup_d = dup_q + 2'd1;
          if (dup_d == 2'd3) begin
            thr_d   = half_thr;
            win_d   = sat((ExtW'(half_thr) << WinFrac) + ExtW'(3 * WinOne));
            phase_d = rcwc_pkg::PH_FAST;
            next_d  = base_q;
            rew     = 1'b1;
          end
        end
      end
    end else if (item_q.command == rcwc_pkg::CMD_TIMEOUT && !done_q) begin
      thr_d = half_thr; win_d = WinOne; dup_d = '0;
      phase_d = rcwc_pkg::PH_SLOW; next_d = base_q; rew = 1'b1;
    end else if (item_q.command == rcwc_pkg::CMD_SEND && !done_q) begin
      if ((ExtW'(outst) << WinFrac) < ExtW'(win_q) && next_q != final_q) begin
        next_d = next_q + SeqBits'(1);
        grant  = 1'b1;
        num    = next_d;
      end
    end
    lim_sum = (ExtW'(mean_d) + (ExtW'(dev_d) << 2)) >> 3;
    lim     = (lim_sum > ExtW'({LimW{1'b1}})) ? '1 : lim_sum[LimW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rcwc_pkg::PH_SLOW; win_q <= WinOne; thr_q <= ThrW'(8);
      dup_q <= '0; base_q <= '0; next_q <= '0; final_q <= '0;
      mean_q <= rcwc_pkg::MeanReset; dev_q <= '0; done_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rcwc_pkg::REG_INIT_THR: begin
          thr_q <= cfg_data_i;
        end
        rcwc_pkg::REG_FIRST_BASE: begin
          base_q <= SeqBits'(cfg_data_i); next_q <= SeqBits'(cfg_data_i);
        end
        rcwc_pkg::REG_FINAL_SEQ: final_q <= SeqBits'(cfg_data_i);
        default: ;
      endcase
    end else if (cmd_i.commit) begin
      phase_q <= phase_d; win_q <= win_d; thr_q <= thr_d; dup_q <= dup_d;
      base_q <= base_d; next_q <= next_d; mean_q <= mean_d; dev_q <= dev_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q.send_granted  <= grant;
      res_q.send_number   <= 16'(num);
      res_q.rewound       <= rew;
      res_q.phase         <= phase_d;
      res_q.window        <= win_d;
      res_q.threshold     <= thr_d;
      res_q.acked_base    <= 16'(base_d);
      res_q.transfer_done <= done_d;
      res_q.timer_limit   <= lim;
    end
  end

  assign out_data_o = res_q;

endmodule

FILE: sv/reno_congestion_window_control_core.sv
// ----------------------------------------------------------------------------
// reno_congestion_window_control_core: Reno sender window control
// Controller plus datapath; one result per input item.
// ----------------------------------------------------------------------------
// an in-order ack in congestion avoidance also runs the divider (restoring
//   divider, one quotient bit a cycle) before the commit
// one item in flight at a time: a new item is taken only once the last one
//   has been committed and no held result is stalled
// reset: asynchronous, active low; item, result and divider data not reset
module reno_congestion_window_control_core #(
  parameter int WinFrac = rcwc_pkg::WinFracDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [rcwc_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  rcwc_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output rcwc_pkg::out_item_t       out_data_o
);

  // command and status between sequencer and datapath
  rcwc_pkg::dp_cmd_t    cmd;
  rcwc_pkg::dp_status_t status;

  rcwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // protocol state, rtt filter, reciprocal divider, result register
  rcwc_dp #(
    .WinFrac (WinFrac)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sv/rcwc_checker.sv
// ----------------------------------------------------------------------------
// rcwc_checker: port-level checks
// Watches the ports of the core over time.
// ----------------------------------------------------------------------------
module rcwc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rcwc_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  a_grant_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.send_granted |-> out_data_o.send_number == '0)
    else $error("number without grant");

  a_grant_norewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.send_granted && out_data_o.rewound))
    else $error("grant and rewind together");

endmodule

bind reno_congestion_window_control_core rcwc_checker u_rcwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Reno window control self-checking bench
// Drives ack, timeout and send events through the valid/stall input channel,
// predicts every result with a local model of the window and RTT state, and
// compares each result transfer field by field. Directed rows first, then
// random well-formed traffic with noise, over several register settings.
// ----------------------------------------------------------------------------
module testbench;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [rcwc_pkg::CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  rcwc_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rcwc_pkg::out_item_t out_data_o;

  always #5 clk_i = ~clk_i;

  reno_congestion_window_control_core dut (.*);

  // local copy of the block state
  logic [15:0] m_first, m_final;
  logic [1:0] m_phase;
  logic [23:0] m_win;
  logic [15:0] m_thr, m_base, m_next;
  logic [1:0] m_dups;
  logic [23:0] m_mean, m_dev;
  logic m_done;

  rcwc_pkg::out_item_t pending_results[$];
  int fail_count = 0;
  longint cycle_count = 0;
  bit long_hold = 0;

  // directed row: item plus optional typed-in expectation
  typedef struct {
    rcwc_pkg::in_item_t item;
    bit fixed;
    rcwc_pkg::out_item_t res;
  } row_t;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  function automatic void model_reset();
    m_first = '0; m_final = '0;
    m_phase = rcwc_pkg::PH_SLOW; m_win = 24'd256; m_thr = 16'd8; m_dups = '0;
    m_base = '0; m_next = '0; m_mean = rcwc_pkg::MeanReset; m_dev = '0; m_done = 1'b0;
  endfunction

  function automatic void track_rtt(input logic [15:0] s);
    logic [63:0] s8, d;
    s8 = 64'(s) << 3;
    m_mean = 24'((64'd7 * m_mean + s8) >> 3);
    d = (s8 > m_mean) ? s8 - m_mean : m_mean - s8;
    m_dev = 24'((64'd3 * m_dev + d) >> 2);
  endfunction

  function automatic logic [23:0] sat24(input logic [63:0] v);
    return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
  endfunction

  function automatic logic [15:0] halved();
    logic [23:0] t;
    t = m_win >> 9;
    return (t > 24'hFFFF) ? 16'hFFFF : t[15:0];
  endfunction

  function automatic rcwc_pkg::out_item_t window_step(input rcwc_pkg::in_item_t it);
    rcwc_pkg::out_item_t r;
    logic [15:0] outst, ack_dist;
    logic [63:0] lim;
    r = '0;
    outst = m_next - m_base;
    if (it.command == rcwc_pkg::CMD_ACK && it.ack_good && !m_done) begin
      ack_dist = it.ack_number - m_base;
      if (ack_dist == 16'd1) begin
        track_rtt(it.rtt_sample);
        m_base = it.ack_number;
        if (outst == 0) m_next = it.ack_number;
        if (m_phase == rcwc_pkg::PH_SLOW) begin
          m_win = sat24(64'(m_win) + 256);
        end else if (m_phase == rcwc_pkg::PH_AVOID) begin
          if (m_win == 0) m_win = 24'd256;
          else m_win = sat24(64'(m_win) + 64'd65536 / m_win);
        end else begin
          m_win = sat24(64'(m_thr) * 256);
          m_phase = rcwc_pkg::PH_AVOID;
        end
        m_dups = '0;
        if (m_phase == rcwc_pkg::PH_SLOW && 64'(m_win) >= 64'(m_thr) * 256)
          m_phase = rcwc_pkg::PH_AVOID;
        if (it.ack_number == m_final) m_done = 1'b1;
      end else if (ack_dist > 1 && ack_dist <= outst) begin
        track_rtt(it.rtt_sample);
        m_base = it.ack_number;
        if (it.ack_number == m_final) m_done = 1'b1;
      end else if (ack_dist == 0) begin
        if (m_phase == rcwc_pkg::PH_FAST) m_win = sat24(64'(m_win) + 256);
        else if (m_dups < 3) m_dups++;
        if (m_dups == 3 && m_phase != rcwc_pkg::PH_FAST) begin
          m_thr = halved();
          m_win = sat24(64'(m_thr) * 256 + 768);
          m_phase = rcwc_pkg::PH_FAST;
          m_next = m_base;
          r.rewound = 1'b1;
        end
      end
    end else if (it.command == rcwc_pkg::CMD_TIMEOUT && !m_done) begin
      m_thr = halved();
      m_win = 24'd256;
      m_dups = '0;
      m_phase = rcwc_pkg::PH_SLOW;
      m_next = m_base;
      r.rewound = 1'b1;
    end else if (it.command == rcwc_pkg::CMD_SEND && !m_done) begin
      if (64'(outst) * 256 < 64'(m_win) && m_next != m_final) begin
        m_next = m_next + 16'd1;
        r.send_granted = 1'b1;
        r.send_number = m_next;
      end
    end
    lim = (64'(m_mean) + 64'd4 * m_dev) >> 3;
    r.phase = m_phase;
    r.window = m_win;
    r.threshold = m_thr;
    r.acked_base = m_base;
    r.transfer_done = m_done;
    r.timer_limit = (lim > 64'h7FFFF) ? 19'h7FFFF : lim[18:0];
    return r;
  endfunction

  // register write; only called while nothing is in flight
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rcwc_pkg::REG_INIT_THR) begin
      m_thr = val;
    end else if (idx == rcwc_pkg::REG_FIRST_BASE) begin
      m_first = val; m_base = val; m_next = val;
    end else if (idx == rcwc_pkg::REG_FINAL_SEQ) begin
      m_final = val;
    end
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // one input transfer; the expectation is queued at acceptance
  task automatic offer(input rcwc_pkg::in_item_t it, input bit gap_ok);
    int gap;
    gap = gap_ok ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results = {pending_results, window_step(it)};
  endtask

  function automatic rcwc_pkg::in_item_t mk(input logic [1:0] c, input logic [15:0] a,
                                            input logic g, input logic [15:0] s);
    rcwc_pkg::in_item_t it;
    it.command = c; it.ack_number = a; it.ack_good = g; it.rtt_sample = s;
    return it;
  endfunction

  // random event with bias toward sequences that move the window
  function automatic rcwc_pkg::in_item_t rand_event();
    int pick;
    logic [15:0] outst, a;
    pick = $urandom_range(0, 99);
    outst = m_next - m_base;
    a = 16'($urandom);
    if (pick < 40)
      return mk(rcwc_pkg::CMD_SEND, 16'($urandom), 1'($urandom), 16'($urandom));
    if (pick < 62) begin
      a = m_base + 16'd1;
      if (outst > 1 && $urandom_range(0, 3) == 0)
        a = m_base + 16'($urandom_range(2, outst));
    end else if (pick < 80) begin
      a = m_base;
    end else if (pick < 84) begin
      return mk(rcwc_pkg::CMD_TIMEOUT, 16'($urandom), 1'($urandom), 16'($urandom));
    end else if (pick < 87) begin
      return mk(2'd3, 16'($urandom), 1'($urandom), 16'($urandom));
    end
    return mk(rcwc_pkg::CMD_ACK, a, ($urandom_range(0, 15) != 0), $urandom_range(0, 1) ?
              16'($urandom_range(0, 4000)) : 16'($urandom));
  endfunction

  // result side: random hold-off per result, one long hold-off, field checks
  initial begin
    int hold;
    rcwc_pkg::out_item_t e;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          e = pending_results.pop_front();
          if (out_data_o.send_granted !== e.send_granted)
            report("send_granted", out_data_o.send_granted, e.send_granted);
          if (out_data_o.send_number !== e.send_number)
            report("send_number", out_data_o.send_number, e.send_number);
          if (out_data_o.rewound !== e.rewound)
            report("rewound", out_data_o.rewound, e.rewound);
          if (out_data_o.phase !== e.phase) report("phase", out_data_o.phase, e.phase);
          if (out_data_o.window !== e.window) report("window", out_data_o.window, e.window);
          if (out_data_o.threshold !== e.threshold)
            report("threshold", out_data_o.threshold, e.threshold);
          if (out_data_o.acked_base !== e.acked_base)
            report("acked_base", out_data_o.acked_base, e.acked_base);
          if (out_data_o.transfer_done !== e.transfer_done)
            report("transfer_done", out_data_o.transfer_done, e.transfer_done);
          if (out_data_o.timer_limit !== e.timer_limit)
            report("timer_limit", out_data_o.timer_limit, e.timer_limit);
        end
        // stretch with no stalls, otherwise a hold drawn by $urandom_range before the next one
        hold = (cycle_count % 3000 < 600) ? 0 : $urandom_range(0, 5);
      end
      if (long_hold) begin
        long_hold = 0;
        hold = 0;
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    rcwc_pkg::out_item_t got_e;
    logic [15:0] fin;
    model_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset values: first_base 0, final 0 (sends refused)
    r.fixed = 1;
    r.item = mk(rcwc_pkg::CMD_SEND, 16'hFFFF, 1'b1, 16'hFFFF);
    r.res = '{send_granted: 1'b0, send_number: 16'd0, rewound: 1'b0,
              phase: rcwc_pkg::PH_SLOW, window: 24'd256, threshold: 16'd8,
              acked_base: 16'd0, transfer_done: 1'b0, timer_limit: 19'd2000};
    rows = {rows, r};
    r.item = mk(2'd3, 16'hFFFF, 1'b1, 16'hFFFF);
    rows = {rows, r};
    r.item = mk(rcwc_pkg::CMD_ACK, 16'd1, 1'b0, 16'hFFFF);  // bad ack ignored
    rows = {rows, r};
    r.fixed = 0;
    foreach (rows[i]) begin
      got_e = window_step(rows[i].item);
      if (rows[i].fixed && got_e !== rows[i].res) report("directed table", 1, 0);
    end
    model_reset();
    foreach (rows[i]) offer(rows[i].item, 1'b1);
    settle();

    write_reg(rcwc_pkg::REG_FINAL_SEQ, 16'd40);
    write_reg(rcwc_pkg::REG_INIT_THR, 16'd3);
    begin
      rcwc_pkg::in_item_t seq[$];
      seq = {mk(rcwc_pkg::CMD_SEND, 16'd0, 1'b0, 16'd0),
             mk(rcwc_pkg::CMD_ACK, 16'd1, 1'b1, 16'd0),
             mk(rcwc_pkg::CMD_SEND, 16'd0, 1'b0, 16'd0),
             mk(rcwc_pkg::CMD_SEND, 16'd0, 1'b0, 16'd0),
             mk(rcwc_pkg::CMD_ACK, 16'd2, 1'b1, 16'hFFFF),
             mk(rcwc_pkg::CMD_SEND, 16'd0, 1'b0, 16'd0),
             mk(rcwc_pkg::CMD_SEND, 16'd0, 1'b0, 16'd0),
             mk(rcwc_pkg::CMD_SEND, 16'd0, 1'b0, 16'd0),
             mk(rcwc_pkg::CMD_ACK, 16'd5, 1'b1, 16'd100),
             mk(rcwc_pkg::CMD_ACK, 16'd5, 1'b1, 16'd100),
             mk(rcwc_pkg::CMD_ACK, 16'd5, 1'b1, 16'd100),
             mk(rcwc_pkg::CMD_ACK, 16'd5, 1'b1, 16'd100),
             mk(rcwc_pkg::CMD_ACK, 16'd5, 1'b1, 16'd100),
             mk(rcwc_pkg::CMD_ACK, 16'd6, 1'b1, 16'd50),
             mk(rcwc_pkg::CMD_ACK, 16'd6, 1'b1, 16'd50),
             mk(rcwc_pkg::CMD_SEND, 16'd0, 1'b0, 16'd0),
             mk(rcwc_pkg::CMD_ACK, 16'd7, 1'b1, 16'd70),
             mk(rcwc_pkg::CMD_TIMEOUT, 16'd0, 1'b1, 16'd0),
             mk(rcwc_pkg::CMD_TIMEOUT, 16'd0, 1'b1, 16'd0),
             mk(rcwc_pkg::CMD_ACK, 16'h8000, 1'b1, 16'd1)};
      foreach (seq[i]) offer(seq[i], 1'b1);
    end
    settle();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 9; ph++) begin
      unique case (ph % 3)
        0: write_reg(rcwc_pkg::REG_INIT_THR, 16'hFFFF);
        1: write_reg(rcwc_pkg::REG_INIT_THR, 16'd1);
        default: write_reg(rcwc_pkg::REG_INIT_THR, 16'($urandom_range(2, 64)));
      endcase
      write_reg(rcwc_pkg::REG_FIRST_BASE,
                (ph == 1) ? 16'hFFF0 : (ph == 2) ? 16'hFFFF : 16'($urandom));
      fin = m_first + ((ph == 3) ? 16'h0 : 16'($urandom_range(30, 400)));
      write_reg(rcwc_pkg::REG_FINAL_SEQ, (ph == 4) ? m_first - 16'd1 : fin);
      for (int n = 0; n < 200; n++) begin
        if (ph == 2 && n == 50) long_hold = 1;
        if (ph == 5 && n == 100) begin
          // sender pauses until every expected result has come
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        offer(rand_event(), (n % 60) > 15);
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
